### rtl/mfc_pkg.sv
// ----------------------------------------------------------------------------
// Metadata frame checker package
// Shared codes for byte roles, error codes and the UTF-8 second-byte rules.
// ----------------------------------------------------------------------------
package mfc_pkg;

    // Role of a byte within the frame; doubles as the parser phase.
    typedef enum logic [2:0] {
        ROLE_VERSION = 3'd0,
        ROLE_COUNT   = 3'd1,
        ROLE_KEYLEN  = 3'd2,
        ROLE_KEY     = 3'd3,
        ROLE_VLEN_HI = 3'd4,
        ROLE_VLEN_LO = 3'd5,
        ROLE_VALUE   = 3'd6,
        ROLE_EXCESS  = 3'd7
    } role_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_SHORT     = 4'd1,
        ERR_LONG      = 4'd2,
        ERR_VERSION   = 4'd3,
        ERR_EMPTY_KEY = 4'd4,
        ERR_TRUNC     = 4'd5,
        ERR_NUL       = 4'd6,
        ERR_UTF8      = 4'd7,
        ERR_TRAILING  = 4'd8
    } err_t;

    // Range rule for the byte following a UTF-8 lead byte.
    typedef enum logic [2:0] {
        RULE_GEN = 3'd0,   // 80..BF
        RULE_E0  = 3'd1,   // A0..BF
        RULE_ED  = 3'd2,   // 80..9F
        RULE_F0  = 3'd3,   // 90..BF
        RULE_F4  = 3'd4    // 80..8F
    } rule_t;

    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hbf;
    localparam logic [7:0] ASCII_MAX   = 8'h7f;
    localparam logic [7:0] LEAD2_LO    = 8'hc2;
    localparam logic [7:0] LEAD2_HI    = 8'hdf;
    localparam logic [7:0] LEAD3_LO    = 8'he0;
    localparam logic [7:0] LEAD3_HI    = 8'hef;
    localparam logic [7:0] LEAD3_SURR  = 8'hed;
    localparam logic [7:0] LEAD4_LO    = 8'hf0;
    localparam logic [7:0] LEAD4_HI    = 8'hf4;
    localparam logic [7:0] E0_LO       = 8'ha0;
    localparam logic [7:0] ED_HI       = 8'h9f;
    localparam logic [7:0] F0_LO       = 8'h90;
    localparam logic [7:0] F4_HI       = 8'h8f;

    localparam logic [7:0]  VERSION_RESET   = 8'd1;
    localparam logic [10:0] MAX_BYTES_RESET = 11'd1024;

    // Register indexes on the configuration port.
    localparam logic REG_VERSION   = 1'b0;
    localparam logic REG_MAX_BYTES = 1'b1;

endpackage

### rtl/metadata_frame_checker_top.sv
// ----------------------------------------------------------------------------
// Metadata frame checker
// Parses a length-prefixed key/value frame byte by byte, tags each byte with
// its role and entry, and reports frame validity on the last byte.
// Each accepted input word yields one result word from the output register.
// Throughput: one word per cycle while m_tready holds the result stream open; all
// parsing and UTF-8 checks finish in the single logic stage between the parser
// state and the output register. Reset: synchronous, active low; parser returns
// to expecting a version byte and the registers to version 1 and a 1024-byte limit.
// ----------------------------------------------------------------------------
module metadata_frame_checker_top #(
    parameter int MAX_FRAME = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // [0] empty_frame
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [15:8] entry_number,
                                   // [19:16] error_code, [23:20] zero
    output logic        m_tlast,   // frame_done
    output logic [3:0]  m_tuser    // [2:0] byte_role, [3] frame_ok
);
    import mfc_pkg::*;

    localparam int BSW  = $clog2(MAX_FRAME + 2);
    localparam int CMPW = (BSW > 11) ? BSW : 11;
    localparam logic [BSW-1:0]  BS_SAT   = BSW'(MAX_FRAME + 1);
    localparam logic [CMPW-1:0] MAX_CMP  = CMPW'(MAX_FRAME);
    localparam logic [CMPW-1:0] TWO_CMP  = CMPW'(2);

    // Configuration registers
    logic [7:0]  ver_reg;
    logic [10:0] max_bytes_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ver_reg       <= VERSION_RESET;
            max_bytes_reg <= MAX_BYTES_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_VERSION) begin
                ver_reg <= pwdata[7:0];
            end else begin
                max_bytes_reg <= pwdata[10:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_MAX_BYTES) begin
            prdata = {21'd0, max_bytes_reg};
        end else begin
            prdata = {24'd0, ver_reg};
        end
    end

    // Parser state
    role_t          phase_reg, phase_next;
    logic [BSW-1:0] bs_reg, bs_next;
    logic [7:0]     el_reg, el_next;
    logic [7:0]     ec_reg, ec_next;
    logic [15:0]    fbl_reg, fbl_next;
    logic [7:0]     lhb_reg, lhb_next;
    logic [1:0]     cont_reg, cont_next;
    rule_t          rule_reg, rule_next;
    err_t           err_reg, err_next;

    // Output register
    logic        m_valid_reg;
    logic [7:0]  out_byte_reg, out_byte_next;
    role_t       role_reg, role_next;
    logic [7:0]  entry_reg, entry_next;
    logic        done_reg, done_next;
    logic        ok_reg, ok_next;
    err_t        code_reg, code_next;

    logic accept;

    assign s_tready = ~m_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        logic [7:0]      b;
        logic [7:0]      lo;
        logic [7:0]      hi;
        logic            text;
        logic            end_field;
        logic            end_ent;
        logic [15:0]     fbl_dec;
        logic [7:0]      el_dec;
        logic [CMPW-1:0] bs_ext;
        logic [CMPW-1:0] lim;

        b         = s_tdata;
        lo        = CONT_LO;
        hi        = CONT_HI;
        text      = 1'b0;
        end_field = 1'b0;
        end_ent   = 1'b0;
        fbl_dec   = fbl_reg - 16'd1;
        el_dec    = el_reg - 8'd1;

        phase_next = phase_reg;
        el_next    = el_reg;
        ec_next    = ec_reg;
        fbl_next   = fbl_reg;
        lhb_next   = lhb_reg;
        cont_next  = cont_reg;
        rule_next  = rule_reg;
        err_next   = err_reg;
        bs_next    = (bs_reg < BS_SAT) ? bs_reg + BSW'(1) : bs_reg;

        out_byte_next = b;
        role_next     = phase_reg;
        entry_next    = 8'd0;
        done_next     = s_tlast;
        ok_next       = 1'b0;
        code_next     = ERR_NONE;

        unique case (phase_reg)
            ROLE_VERSION: begin
                if (b != ver_reg && err_next == ERR_NONE) err_next = ERR_VERSION;
                phase_next = ROLE_COUNT;
            end
            ROLE_COUNT: begin
                el_next    = b;
                ec_next    = 8'd0;
                phase_next = (b == 8'd0) ? ROLE_EXCESS : ROLE_KEYLEN;
            end
            ROLE_KEYLEN: begin
                entry_next = ec_reg;
                fbl_next   = {8'd0, b};
                cont_next  = 2'd0;
                rule_next  = RULE_GEN;
                if (b == 8'd0) begin
                    if (err_next == ERR_NONE) err_next = ERR_EMPTY_KEY;
                    phase_next = ROLE_VLEN_HI;
                end else begin
                    phase_next = ROLE_KEY;
                end
            end
            ROLE_KEY: begin
                entry_next = ec_reg;
                text       = 1'b1;
                fbl_next   = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    end_field  = 1'b1;
                    phase_next = ROLE_VLEN_HI;
                end
            end
            ROLE_VLEN_HI: begin
                entry_next = ec_reg;
                lhb_next   = b;
                phase_next = ROLE_VLEN_LO;
            end
            ROLE_VLEN_LO: begin
                entry_next = ec_reg;
                fbl_next   = {lhb_reg, b};
                cont_next  = 2'd0;
                rule_next  = RULE_GEN;
                if ({lhb_reg, b} == 16'd0) begin
                    end_ent = 1'b1;
                end else begin
                    phase_next = ROLE_VALUE;
                end
            end
            ROLE_VALUE: begin
                entry_next = ec_reg;
                text       = 1'b1;
                fbl_next   = fbl_dec;
                if (fbl_dec == 16'd0) begin
                    end_field = 1'b1;
                    end_ent   = 1'b1;
                end
            end
            ROLE_EXCESS: begin
                if (err_next == ERR_NONE) err_next = ERR_TRAILING;
            end
            default: begin
                phase_next = ROLE_EXCESS;
            end
        endcase

        // NUL is checked ahead of UTF-8 on the same byte.
        if (text) begin
            if (b == 8'd0 && err_next == ERR_NONE) err_next = ERR_NUL;
            rule_next = RULE_GEN;
            if (cont_reg != 2'd0) begin
                case (rule_reg)
                    RULE_E0: lo = E0_LO;
                    RULE_ED: hi = ED_HI;
                    RULE_F0: lo = F0_LO;
                    RULE_F4: hi = F4_HI;
                    default: ;
                endcase
                if (b < lo || b > hi) begin
                    if (err_next == ERR_NONE) err_next = ERR_UTF8;
                    cont_next = 2'd0;
                end else begin
                    cont_next = cont_reg - 2'd1;
                end
            end else if (b > ASCII_MAX) begin
                if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                    cont_next = 2'd1;
                end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                    cont_next = 2'd2;
                    if (b == LEAD3_LO) rule_next = RULE_E0;
                    else if (b == LEAD3_SURR) rule_next = RULE_ED;
                end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                    cont_next = 2'd3;
                    if (b == LEAD4_LO) rule_next = RULE_F0;
                    else if (b == LEAD4_HI) rule_next = RULE_F4;
                end else if (err_next == ERR_NONE) begin
                    err_next = ERR_UTF8;
                end
            end
        end

        // A sequence still open when the field ends is malformed.
        if (end_field) begin
            if (cont_next != 2'd0 && err_next == ERR_NONE) err_next = ERR_UTF8;
            cont_next = 2'd0;
            rule_next = RULE_GEN;
        end

        if (end_ent) begin
            el_next    = el_dec;
            ec_next    = ec_reg + 8'd1;
            phase_next = (el_dec == 8'd0) ? ROLE_EXCESS : ROLE_KEYLEN;
        end

        bs_ext = CMPW'(bs_next);
        lim    = (CMPW'(max_bytes_reg) > MAX_CMP) ? MAX_CMP : CMPW'(max_bytes_reg);

        if (s_tlast) begin
            if (bs_ext < TWO_CMP)                code_next = ERR_SHORT;
            else if (bs_ext > lim)               code_next = ERR_LONG;
            else if (err_next != ERR_NONE)       code_next = err_next;
            else if (phase_next != ROLE_EXCESS)  code_next = ERR_TRUNC;
            else                                 code_next = ERR_NONE;
            ok_next = (code_next == ERR_NONE);
        end

        // The last word of a frame, or a zero-length frame, starts afresh.
        if (s_tlast || s_tuser) begin
            phase_next = ROLE_VERSION;
            bs_next    = '0;
            el_next    = 8'd0;
            ec_next    = 8'd0;
            fbl_next   = 16'd0;
            lhb_next   = 8'd0;
            cont_next  = 2'd0;
            rule_next  = RULE_GEN;
            err_next   = ERR_NONE;
        end

        if (s_tuser) begin
            out_byte_next = 8'd0;
            role_next     = ROLE_VERSION;
            entry_next    = 8'd0;
            done_next     = 1'b1;
            ok_next       = 1'b1;
            code_next     = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= ROLE_VERSION;
            bs_reg      <= '0;
            el_reg      <= 8'd0;
            ec_reg      <= 8'd0;
            fbl_reg     <= 16'd0;
            lhb_reg     <= 8'd0;
            cont_reg    <= 2'd0;
            rule_reg    <= RULE_GEN;
            err_reg     <= ERR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                bs_reg    <= bs_next;
                el_reg    <= el_next;
                ec_reg    <= ec_next;
                fbl_reg   <= fbl_next;
                lhb_reg   <= lhb_next;
                cont_reg  <= cont_next;
                rule_reg  <= rule_next;
                err_reg   <= err_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_byte_reg <= out_byte_next;
            role_reg     <= role_next;
            entry_reg    <= entry_next;
            done_reg     <= done_next;
            ok_reg       <= ok_next;
            code_reg     <= code_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, code_reg, entry_reg, out_byte_reg};
    assign m_tlast  = done_reg;
    assign m_tuser  = {ok_reg, role_reg};

endmodule
